// ===== sv/imu_complementary_attitude_filter_assert.svh =====
// assertion macros for the attitude filter checker
// expects clk and rst_n in the scope where a macro is used
`ifndef IMU_COMPLEMENTARY_ATTITUDE_FILTER_ASSERT_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_FILTER_ASSERT_SVH

// same-cycle implication
`define IMUCF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imucf check failed");

// next-cycle implication
`define IMUCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imucf check failed");

`endif

// ===== sv/imucf_pkg.sv =====
// shared constants, types and helper functions of the attitude filter
// no dependencies
package imucf_pkg;

    localparam int CORDIC_STEPS        = 16;
    localparam int ANGLE_FRACTION_BITS = 16;

    localparam int FRAC_EFF  = (ANGLE_FRACTION_BITS < 8) ? 8 :
                               ((ANGLE_FRACTION_BITS > 24) ? 24 : ANGLE_FRACTION_BITS);
    localparam int STEPS_EFF = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    // table rounding from q24 down to the accumulator precision
    localparam int ANGLE_SHIFT = 24 - FRAC_EFF;
    localparam int ANGLE_RPOS  = (ANGLE_SHIFT > 0) ? ANGLE_SHIFT - 1 : 0;
    // final conversion of the accumulator to q16
    localparam int OUT_DN   = (FRAC_EFF >= 16) ? FRAC_EFF - 16 : 0;
    localparam int OUT_UP   = (FRAC_EFF < 16) ? 16 - FRAC_EFF : 0;
    localparam int OUT_RPOS = (OUT_DN > 0) ? OUT_DN - 1 : 0;

    localparam logic signed [33:0] HALF_TURN = 34'sd180 <<< FRAC_EFF;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_GAIN  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_TIME    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROLL_OFFSET  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PITCH_OFFSET = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_YAW_OFFSET   = 3'd4;

    localparam logic [16:0] GAIN_RESET = 17'd64225;
    localparam logic [16:0] GAIN_ONE   = 17'd65536;
    localparam logic [15:0] DT_RESET   = 16'd655;

    typedef struct packed {
        logic               start;
        logic signed [17:0] y;
        logic signed [17:0] x;
    } cordic_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] angle;
    } cordic_rsp_t;

    // atan(2^-i) in degrees, q24
    function automatic logic signed [33:0] atan_q24(input logic [4:0] idx);
        logic signed [33:0] v;
        unique case (idx)
            5'd0:  v = 34'sd754974720;
            5'd1:  v = 34'sd445687602;
            5'd2:  v = 34'sd235489088;
            5'd3:  v = 34'sd119537938;
            5'd4:  v = 34'sd60000934;
            5'd5:  v = 34'sd30029717;
            5'd6:  v = 34'sd15018523;
            5'd7:  v = 34'sd7509720;
            5'd8:  v = 34'sd3754917;
            5'd9:  v = 34'sd1877466;
            5'd10: v = 34'sd938734;
            5'd11: v = 34'sd469367;
            5'd12: v = 34'sd234684;
            5'd13: v = 34'sd117342;
            5'd14: v = 34'sd58671;
            5'd15: v = 34'sd29335;
            5'd16: v = 34'sd14668;
            5'd17: v = 34'sd7334;
            5'd18: v = 34'sd3667;
            5'd19: v = 34'sd1833;
            5'd20: v = 34'sd917;
            5'd21: v = 34'sd458;
            5'd22: v = 34'sd229;
            5'd23: v = 34'sd115;
            5'd24: v = 34'sd57;
            5'd25: v = 34'sd29;
            5'd26: v = 34'sd14;
            5'd27: v = 34'sd7;
            5'd28: v = 34'sd4;
            5'd29: v = 34'sd2;
            5'd30: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [33:0] atan_step(input logic [4:0] idx);
        logic signed [33:0] v;
        v = atan_q24(idx);
        if (ANGLE_SHIFT == 0)
            return v;
        return (v + (34'sd1 <<< ANGLE_RPOS)) >>> ANGLE_SHIFT;
    endfunction

    function automatic logic signed [31:0] cordic_round(input logic signed [33:0] z);
        logic signed [33:0] r;
        if (OUT_UP > 0)
            r = z <<< OUT_UP;
        else if (OUT_DN > 0)
            r = (z + (34'sd1 <<< OUT_RPOS)) >>> OUT_DN;
        else
            r = z;
        return r[31:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607)
            return 24'sh7fffff;
        else if (v < -64'sd8388608)
            return 24'sh800000;
        return v[23:0];
    endfunction

endpackage

// ===== sv/imucf_cordic.sv =====
// iterative vectoring cordic giving atan2(y, x) in degrees, q16.16
// depends on imucf_pkg
module imucf_cordic (
    input  logic                   clk,
    input  logic                   rst_n,
    input  imucf_pkg::cordic_req_t req,
    output imucf_pkg::cordic_rsp_t rsp
);
    import imucf_pkg::*;

    typedef enum logic {C_IDLE, C_RUN} cstate_t;

    cstate_t            state_reg;
    logic               done_reg;
    logic signed [31:0] angle_reg;
    logic signed [35:0] x_reg;
    logic signed [35:0] y_reg;
    logic signed [33:0] z_reg;
    logic [5:0]         i_reg;

    logic signed [35:0] x_in;
    logic signed [35:0] y_in;
    logic signed [35:0] x_sh;
    logic signed [35:0] y_sh;
    logic signed [33:0] step_a;
    logic signed [33:0] z_step;
    logic               last_step;

    assign x_in      = 36'(req.x) <<< 14;
    assign y_in      = 36'(req.y) <<< 14;
    assign x_sh      = x_reg >>> i_reg;
    assign y_sh      = y_reg >>> i_reg;
    assign step_a    = atan_step(i_reg[4:0]);
    assign z_step    = (y_reg > 0) ? z_reg + step_a : z_reg - step_a;
    assign last_step = (i_reg == 6'(STEPS_EFF - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (req.start)
                    begin
                        i_reg <= 6'd0;
                        if (req.x == 18'sd0 && req.y == 18'sd0)
                        begin
                            // zero vector
                            angle_reg <= 32'sd0;
                            done_reg  <= 1'b1;
                        end
                        else if (req.x < 0)
                        begin
                            // left half plane: rotate by half a turn first
                            z_reg     <= (req.y >= 0) ? HALF_TURN : -HALF_TURN;
                            x_reg     <= -x_in;
                            y_reg     <= -y_in;
                            state_reg <= C_RUN;
                        end
                        else
                        begin
                            z_reg     <= 34'sd0;
                            x_reg     <= x_in;
                            y_reg     <= y_in;
                            state_reg <= C_RUN;
                        end
                    end
                end
                C_RUN:
                begin
                    if (y_reg == 36'sd0)
                    begin
                        angle_reg <= cordic_round(z_reg);
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                    else
                    begin
                        if (y_reg > 0)
                        begin
                            x_reg <= x_reg + y_sh;
                            y_reg <= y_reg - x_sh;
                        end
                        else
                        begin
                            x_reg <= x_reg - y_sh;
                            y_reg <= y_reg + x_sh;
                        end
                        z_reg <= z_step;
                        i_reg <= i_reg + 6'd1;
                        if (last_step)
                        begin
                            angle_reg <= cordic_round(z_step);
                            done_reg  <= 1'b1;
                            state_reg <= C_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.angle = angle_reg;

endmodule

// ===== sv/imu_complementary_attitude_filter.sv =====
// top level of the imu complementary attitude filter
// depends on imucf_pkg and imucf_cordic
//
// One imu sample per request gives one roll/pitch/yaw result in degrees (q16.16) plus a
// zero-magnitude flag. The block works on one sample at a time; normalization is skipped
// when the filtered acceleration is all zero. The work is done by the single shared
// multiply-accumulate unit (low pass, mix and integration lanes), the one-bit-per-cycle
// square root and divider, and the cordic loop, which ends early when the residual hits
// zero. A finished result sits in an output register, so the next sample is taken while
// the result waits; configuration may be written any time the block is idle and takes
// effect on the next sample.
module imu_complementary_attitude_filter (
    input  logic                                clk,
    input  logic                                rst_n,
    // input sample stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bit each)
    input  logic [95:0]                         s_axis_tdata,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // roll_out, pitch_out, yaw_out (32 bit each)
    output logic [95:0]                         m_axis_tdata,
    // zero_magnitude
    output logic [0:0]                          m_axis_tuser,
    // register writes
    input  logic                                cfg_wr_en,
    input  logic [imucf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [imucf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import imucf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LPA, S_SQ, S_SQRT, S_DIV_LD, S_DIV_RUN,
        S_CORD_LD, S_CORD_WT, S_LPR, S_INTG, S_MIX, S_OUT
    } state_t;

    // control
    state_t      state_reg;
    logic [1:0]  lane_reg;
    logic [1:0]  sub_reg;
    logic [4:0]  it_reg;
    logic        m_valid_reg;

    // configuration
    logic [16:0]        gain_reg;
    logic [15:0]        dt_reg;
    logic signed [31:0] off_reg [3];

    // filter state
    logic signed [17:0] unit_reg [3];
    logic signed [23:0] sr_reg   [3];
    logic signed [31:0] est_reg  [3];

    // per-request working storage
    logic signed [15:0] accel_reg [3];
    logic signed [15:0] rate_reg  [3];
    logic signed [20:0] t_reg     [3];
    logic signed [31:0] ang_reg   [3];
    logic signed [63:0] acc_reg;
    logic               zero_reg;
    logic [40:0]        sq_rem_reg;
    logic [40:0]        sq_root_reg;
    logic [40:0]        sq_bit_reg;
    logic [20:0]        dv_rem_reg;
    logic [17:0]        dv_num_reg;
    logic [17:0]        dv_q_reg;
    logic [95:0]        out_data_reg;
    logic               out_zero_reg;

    // shared multiply-accumulate
    logic signed [24:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [57:0] prod;
    logic               mac_en;
    logic               mac_clr;
    logic signed [63:0] acc_next;

    logic [1:0]         idx;
    logic [16:0]        g_val;
    logic [16:0]        ng_val;
    logic signed [63:0] acc_r16;
    logic signed [63:0] acc_r15;
    logic signed [63:0] est_ext;
    logic signed [63:0] est_int;

    // square root step
    logic [40:0] sq_trial;
    logic        sq_ge;

    // divider step
    logic [20:0] mag;
    logic [20:0] t_abs;
    logic [36:0] dv_numer;
    logic [21:0] dv_remx;
    logic        dv_ge;
    logic [17:0] dv_q_next;
    logic [17:0] dv_q_sat;
    logic signed [17:0] unit_new;

    cordic_req_t cord_req;
    cordic_rsp_t cord_rsp;

    logic s_req;
    logic out_load;

    assign s_req  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // squares walk the lanes with sub_reg, everything else with lane_reg
    assign idx = (state_reg == S_SQ) ? sub_reg : lane_reg;

    // gain above one acts as one
    assign g_val  = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;
    assign ng_val = 17'(18'd65536 - {1'b0, g_val});

    always_comb
    begin
        mul_a   = 25'sd0;
        mul_b   = 33'sd0;
        mac_en  = 1'b0;
        mac_clr = 1'b0;
        unique case (state_reg)
            S_LPA:
            begin
                if (sub_reg == 2'd0)
                begin
                    mul_a   = $signed({8'd0, g_val});
                    mul_b   = 33'(unit_reg[idx]);
                    mac_en  = 1'b1;
                    mac_clr = 1'b1;
                end
                else if (sub_reg == 2'd1)
                begin
                    mul_a  = $signed({8'd0, ng_val});
                    mul_b  = 33'(accel_reg[idx]) <<< 4;
                    mac_en = 1'b1;
                end
            end
            S_SQ:
            begin
                if (sub_reg != 2'd3)
                begin
                    mul_a   = 25'(t_reg[idx]);
                    mul_b   = 33'(t_reg[idx]);
                    mac_en  = 1'b1;
                    mac_clr = (sub_reg == 2'd0);
                end
            end
            S_LPR:
            begin
                if (sub_reg == 2'd0)
                begin
                    mul_a   = $signed({8'd0, g_val});
                    mul_b   = 33'(sr_reg[idx]);
                    mac_en  = 1'b1;
                    mac_clr = 1'b1;
                end
                else if (sub_reg == 2'd1)
                begin
                    mul_a  = $signed({8'd0, ng_val});
                    mul_b  = 33'(rate_reg[idx]) <<< 8;
                    mac_en = 1'b1;
                end
            end
            S_INTG:
            begin
                if (sub_reg == 2'd0)
                begin
                    mul_a   = 25'(sr_reg[idx]);
                    mul_b   = $signed({17'd0, dt_reg});
                    mac_en  = 1'b1;
                    mac_clr = 1'b1;
                end
            end
            S_MIX:
            begin
                if (sub_reg == 2'd0)
                begin
                    mul_a   = $signed({8'd0, g_val});
                    mul_b   = 33'(est_reg[idx]);
                    mac_en  = 1'b1;
                    mac_clr = 1'b1;
                end
                else if (sub_reg == 2'd1)
                begin
                    mul_a  = $signed({8'd0, ng_val});
                    // pitch mixes its accelerometer angle with a minus sign
                    mul_b  = (lane_reg == 2'd1) ? -(33'(ang_reg[idx])) : 33'(ang_reg[idx]);
                    mac_en = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign acc_next = mac_clr ? 64'(prod) : acc_reg + 64'(prod);

    // rounding shifts of the accumulator
    assign acc_r16 = (acc_reg + 64'sd32768) >>> 16;
    assign acc_r15 = (acc_reg + 64'sd16384) >>> 15;

    // rate integration, pitch runs with a minus sign
    assign est_ext = 64'(est_reg[idx]);
    assign est_int = (lane_reg == 2'd1) ? est_ext - acc_r15 : est_ext + acc_r15;

    // digit-by-digit square root, two bits of the radicand per cycle
    assign sq_trial = sq_root_reg + sq_bit_reg;
    assign sq_ge    = (sq_rem_reg >= sq_trial);

    // restoring division for |t| * 65536 / magnitude, rounded
    assign mag       = sq_root_reg[20:0];
    assign t_abs     = t_reg[idx][20] ? 21'(-t_reg[idx]) : 21'(t_reg[idx]);
    assign dv_numer  = {t_abs, 16'd0} + 37'(mag >> 1);
    assign dv_remx   = {dv_rem_reg, dv_num_reg[17]};
    assign dv_ge     = (dv_remx >= {1'b0, mag});
    assign dv_q_next = {dv_q_reg[16:0], dv_ge};
    assign dv_q_sat  = (dv_q_next > 18'd65536) ? 18'd65536 : dv_q_next;
    assign unit_new  = t_reg[idx][20] ? -$signed(dv_q_sat) : $signed(dv_q_sat);

    // angle pairs: roll (y,z), pitch (x,z), yaw (y,x)
    always_comb
    begin
        cord_req.start = (state_reg == S_CORD_LD);
        unique case (lane_reg)
            2'd0:
            begin
                cord_req.y = unit_reg[1];
                cord_req.x = unit_reg[2];
            end
            2'd1:
            begin
                cord_req.y = unit_reg[0];
                cord_req.x = unit_reg[2];
            end
            default:
            begin
                cord_req.y = unit_reg[1];
                cord_req.x = unit_reg[0];
            end
        endcase
    end

    imucf_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cord_req),
        .rsp   (cord_rsp)
    );

    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_axis_tready);

    // sequencer, configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            lane_reg    <= 2'd0;
            sub_reg     <= 2'd0;
            it_reg      <= 5'd0;
            m_valid_reg <= 1'b0;
            gain_reg    <= GAIN_RESET;
            dt_reg      <= DT_RESET;
            for (int k = 0; k < 3; k++)
            begin
                off_reg[k]  <= 32'sd0;
                unit_reg[k] <= 18'sd0;
                sr_reg[k]   <= 24'sd0;
                est_reg[k]  <= 32'sd0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_FILTER_GAIN:  gain_reg   <= cfg_data[16:0];
                    REG_STEP_TIME:    dt_reg     <= cfg_data[15:0];
                    REG_ROLL_OFFSET:  off_reg[0] <= $signed(cfg_data);
                    REG_PITCH_OFFSET: off_reg[1] <= $signed(cfg_data);
                    REG_YAW_OFFSET:   off_reg[2] <= $signed(cfg_data);
                    default:
                    begin
                    end
                endcase
            end

            if (mac_en)
                acc_reg <= acc_next;

            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_req)
                    begin
                        accel_reg[0] <= $signed(s_axis_tdata[15:0]);
                        accel_reg[1] <= $signed(s_axis_tdata[31:16]);
                        accel_reg[2] <= $signed(s_axis_tdata[47:32]);
                        rate_reg[0]  <= $signed(s_axis_tdata[63:48]);
                        rate_reg[1]  <= $signed(s_axis_tdata[79:64]);
                        rate_reg[2]  <= $signed(s_axis_tdata[95:80]);
                        lane_reg     <= 2'd0;
                        sub_reg      <= 2'd0;
                        state_reg    <= S_LPA;
                    end
                end
                // acceleration low pass, q.16
                S_LPA:
                begin
                    if (sub_reg == 2'd2)
                    begin
                        t_reg[idx] <= acc_r16[20:0];
                        sub_reg    <= 2'd0;
                        if (lane_reg == 2'd2)
                            state_reg <= S_SQ;
                        else
                            lane_reg <= lane_reg + 2'd1;
                    end
                    else
                        sub_reg <= sub_reg + 2'd1;
                end
                // sum of squares
                S_SQ:
                begin
                    if (sub_reg == 2'd3)
                    begin
                        sub_reg  <= 2'd0;
                        lane_reg <= 2'd0;
                        zero_reg <= (acc_reg == 64'sd0);
                        if (acc_reg == 64'sd0)
                            state_reg <= S_CORD_LD;
                        else
                        begin
                            sq_rem_reg  <= acc_reg[40:0];
                            sq_root_reg <= 41'd0;
                            sq_bit_reg  <= 41'd1 << 40;
                            it_reg      <= 5'd0;
                            state_reg   <= S_SQRT;
                        end
                    end
                    else
                        sub_reg <= sub_reg + 2'd1;
                end
                S_SQRT:
                begin
                    if (sq_ge)
                    begin
                        sq_rem_reg  <= sq_rem_reg - sq_trial;
                        sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
                    end
                    else
                        sq_root_reg <= sq_root_reg >> 1;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (it_reg == 5'd20)
                        state_reg <= S_DIV_LD;
                    else
                        it_reg <= it_reg + 5'd1;
                end
                S_DIV_LD:
                begin
                    dv_rem_reg <= 21'(dv_numer[36:18]);
                    dv_num_reg <= dv_numer[17:0];
                    dv_q_reg   <= 18'd0;
                    it_reg     <= 5'd0;
                    state_reg  <= S_DIV_RUN;
                end
                S_DIV_RUN:
                begin
                    dv_rem_reg <= dv_ge ? 21'(dv_remx - {1'b0, mag}) : dv_remx[20:0];
                    dv_num_reg <= dv_num_reg << 1;
                    dv_q_reg   <= dv_q_next;
                    if (it_reg == 5'd17)
                    begin
                        unit_reg[idx] <= unit_new;
                        if (lane_reg == 2'd2)
                        begin
                            lane_reg  <= 2'd0;
                            state_reg <= S_CORD_LD;
                        end
                        else
                        begin
                            lane_reg  <= lane_reg + 2'd1;
                            state_reg <= S_DIV_LD;
                        end
                    end
                    else
                        it_reg <= it_reg + 5'd1;
                end
                S_CORD_LD:
                begin
                    state_reg <= S_CORD_WT;
                end
                S_CORD_WT:
                begin
                    if (cord_rsp.done)
                    begin
                        ang_reg[idx] <= cord_rsp.angle;
                        if (lane_reg == 2'd2)
                        begin
                            lane_reg  <= 2'd0;
                            sub_reg   <= 2'd0;
                            state_reg <= S_LPR;
                        end
                        else
                        begin
                            lane_reg  <= lane_reg + 2'd1;
                            state_reg <= S_CORD_LD;
                        end
                    end
                end
                // rate low pass with 24 bit saturation
                S_LPR:
                begin
                    if (sub_reg == 2'd2)
                    begin
                        sr_reg[idx] <= sat24(acc_r16);
                        sub_reg     <= 2'd0;
                        if (lane_reg == 2'd2)
                        begin
                            lane_reg  <= 2'd0;
                            state_reg <= S_INTG;
                        end
                        else
                            lane_reg <= lane_reg + 2'd1;
                    end
                    else
                        sub_reg <= sub_reg + 2'd1;
                end
                S_INTG:
                begin
                    if (sub_reg == 2'd1)
                    begin
                        est_reg[idx] <= sat32(est_int);
                        sub_reg      <= 2'd0;
                        if (lane_reg == 2'd2)
                        begin
                            lane_reg  <= 2'd0;
                            state_reg <= S_MIX;
                        end
                        else
                            lane_reg <= lane_reg + 2'd1;
                    end
                    else
                        sub_reg <= sub_reg + 2'd1;
                end
                // complementary mix with the accelerometer angle
                S_MIX:
                begin
                    if (sub_reg == 2'd2)
                    begin
                        est_reg[idx] <= sat32(acc_r16);
                        sub_reg      <= 2'd0;
                        if (lane_reg == 2'd2)
                        begin
                            lane_reg  <= 2'd0;
                            state_reg <= S_OUT;
                        end
                        else
                            lane_reg <= lane_reg + 2'd1;
                    end
                    else
                        sub_reg <= sub_reg + 2'd1;
                end
                // wait for the output register to free up
                S_OUT:
                begin
                    if (out_load)
                    begin
                        out_data_reg[31:0]  <= sat32(64'(est_reg[0]) - 64'(off_reg[0]));
                        out_data_reg[63:32] <= sat32(64'(est_reg[1]) - 64'(off_reg[1]));
                        out_data_reg[95:64] <= sat32(64'(est_reg[2]) - 64'(off_reg[2]));
                        out_zero_reg        <= zero_reg;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_zero_reg;

endmodule

// ===== sv/imucf_checker.sv =====
// port-level checks of the attitude filter, bound to the top level
// depends on imu_complementary_attitude_filter_assert.svh
`include "imu_complementary_attitude_filter_assert.svh"

module imucf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // a stalled result holds
    `IMUCF_ASSERT_NEXT(a_hold_data, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `IMUCF_ASSERT_NEXT(a_hold_flag, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tuser))

    // one request at a time: busy right after taking one
    `IMUCF_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a new result only comes out of a busy block
    `IMUCF_ASSERT_NOW(a_result_from_busy, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

bind imu_complementary_attitude_filter imucf_checker u_imucf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
